// ===== src/rsq_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the ray/square occlusion test.
// No dependencies.
package rsq_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_ENTRIES    = 24;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // Datapath widths
    localparam int AW   = 34;       // rotated half-extent a, b
    localparam int CW   = 36;       // corner coordinate
    localparam int SW   = CW + 1;   // edge vector and origin-to-corner vector
    localparam int DW   = 16 + SW + 1;
    localparam int TW   = 2 * SW + 1;
    localparam int CMPW = 104;

    localparam logic [1:0] OUT_HIT    = 2'd0;
    localparam logic [1:0] OUT_BEHIND = 2'd1;
    localparam logic [1:0] OUT_BEYOND = 2'd2;
    localparam logic [1:0] OUT_MISS   = 2'd3;

    typedef logic [CW-1:0] t_corner;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [30:0] reach;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [29:0] h;
        logic [15:0] heading;
        logic [1:0]  outcome;
    } t_geom;

    typedef struct packed {
        t_corner [3:0] x;
        t_corner [3:0] y;
    } t_quad;

    // Angle table in 2^32 per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            default: v = 32'd81;
        endcase
        return v;
    endfunction

endpackage

// ===== src/rsq_front.sv =====
// Early rejection: obstacle behind the origin or beyond reach, three stages.
// Depends on rsq_pkg.
module rsq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  rsq_pkg::t_geom i_geom,
    output logic          o_valid,
    output rsq_pkg::t_geom o_geom
);

    logic                r_v1, r_v2, r_v3;
    rsq_pkg::t_geom      r_g1, r_g2, r_g3;
    logic signed [32:0]  r_tx, r_ty;
    logic signed [48:0]  r_pdx, r_pdy;
    logic signed [65:0]  r_sqx, r_sqy;
    logic [61:0]         r_rr;
    logic signed [49:0]  n_dot;
    logic [66:0]         n_sq;
    logic [1:0]          n_outcome;
    rsq_pkg::t_geom      n_g3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_dot = 50'(r_pdx) + 50'(r_pdy);
        n_sq  = 67'(unsigned'(r_sqx)) + 67'(unsigned'(r_sqy));
        if (n_dot < 0) begin
            n_outcome = rsq_pkg::OUT_BEHIND;
        end else if (n_sq > 67'(r_rr)) begin
            n_outcome = rsq_pkg::OUT_BEYOND;
        end else begin
            n_outcome = rsq_pkg::OUT_MISS;
        end
        n_g3         = r_g2;
        n_g3.outcome = n_outcome;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1  <= i_geom;
            r_tx  <= $signed({i_geom.cx[31], i_geom.cx}) - $signed({i_geom.ox[31], i_geom.ox});
            r_ty  <= $signed({i_geom.cy[31], i_geom.cy}) - $signed({i_geom.oy[31], i_geom.oy});
            r_g2  <= r_g1;
            r_pdx <= r_tx * $signed(r_g1.dx);
            r_pdy <= r_ty * $signed(r_g1.dy);
            r_sqx <= r_tx * r_tx;
            r_sqy <= r_ty * r_ty;
            r_rr  <= r_g1.reach * r_g1.reach;
            r_g3  <= n_g3;
        end
    end

    assign o_valid = r_v3;
    assign o_geom  = r_g3;

endmodule

// ===== src/rsq_cordic.sv =====
// Pipelined CORDIC, one rotation step per stage, giving cosine and sine in Q1.30.
// Depends on rsq_pkg.
module rsq_cordic #(
    parameter int CORDIC_STEPS = rsq_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rsq_pkg::t_geom     i_geom,
    output logic               o_valid,
    output rsq_pkg::t_geom     o_geom,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int NSTEP = (CORDIC_STEPS < rsq_pkg::ANGLE_ENTRIES) ?
                           CORDIC_STEPS : rsq_pkg::ANGLE_ENTRIES;

    logic               r_v [0:NSTEP];
    logic               r_f [0:NSTEP];
    rsq_pkg::t_geom     r_g [0:NSTEP];
    logic signed [33:0] r_x [0:NSTEP];
    logic signed [33:0] r_y [0:NSTEP];
    logic signed [33:0] r_z [0:NSTEP];
    logic [31:0]        n_z0;
    logic               n_flip;

    // Fold the angle into the right half plane
    always_comb begin
        n_z0   = {i_geom.heading, 16'h0000};
        n_flip = n_z0[31] ^ n_z0[30];
        if (n_flip) begin
            n_z0[31] = ~n_z0[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= n_flip;
            r_g[0] <= i_geom;
            r_x[0] <= rsq_pkg::CORDIC_START;
            r_y[0] <= '0;
            r_z[0] <= 34'($signed(n_z0));
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic signed [33:0] w_atan;
        assign w_atan = $signed({2'b00, rsq_pkg::atan_turn(k)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[k+1] <= r_f[k];
                r_g[k+1] <= r_g[k];
                if (!r_z[k][33]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - w_atan;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + w_atan;
                end
            end
        end
    end

    assign o_valid = r_v[NSTEP];
    assign o_geom  = r_g[NSTEP];
    assign o_cos   = r_f[NSTEP] ? -r_x[NSTEP] : r_x[NSTEP];
    assign o_sin   = r_f[NSTEP] ? -r_y[NSTEP] : r_y[NSTEP];

endmodule

// ===== src/rsq_corner.sv =====
// Scales the half side by cosine and sine and forms the four rotated corners, two stages.
// Depends on rsq_pkg.
module rsq_corner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rsq_pkg::t_geom     i_geom,
    input  logic signed [33:0] i_cos,
    input  logic signed [33:0] i_sin,
    output logic               o_valid,
    output rsq_pkg::t_geom     o_geom,
    output rsq_pkg::t_quad     o_quad
);

    localparam int AW = rsq_pkg::AW;
    localparam int CW = rsq_pkg::CW;

    logic               r_v1, r_v2;
    rsq_pkg::t_geom     r_g1, r_g2;
    logic signed [65:0] r_hc, r_hs;
    rsq_pkg::t_quad     r_quad;
    logic signed [65:0] n_hc_r, n_hs_r;
    logic signed [AW-1:0] n_a, n_b;
    logic signed [CW-1:0] n_p, n_q, n_cx, n_cy;
    rsq_pkg::t_quad     n_quad;

    always_comb begin
        n_hc_r = r_hc + (66'sd1 <<< 29);
        n_hs_r = r_hs + (66'sd1 <<< 29);
        // Axis aligned: take the half side as is
        if (r_g1.heading == 16'h0000) begin
            n_a = AW'($signed({1'b0, r_g1.h}));
            n_b = '0;
        end else begin
            n_a = n_hc_r[AW+29:30];
            n_b = n_hs_r[AW+29:30];
        end
        n_p  = CW'(n_a) + CW'(n_b);
        n_q  = CW'(n_a) - CW'(n_b);
        n_cx = CW'($signed(r_g1.cx));
        n_cy = CW'($signed(r_g1.cy));
        n_quad.x[0] = n_cx - n_p;  n_quad.y[0] = n_cy + n_q;
        n_quad.x[1] = n_cx + n_q;  n_quad.y[1] = n_cy + n_p;
        n_quad.x[2] = n_cx + n_p;  n_quad.y[2] = n_cy - n_q;
        n_quad.x[3] = n_cx - n_q;  n_quad.y[3] = n_cy - n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1   <= i_geom;
            r_hc   <= $signed({1'b0, i_geom.h}) * i_cos;
            r_hs   <= $signed({1'b0, i_geom.h}) * i_sin;
            r_g2   <= r_g1;
            r_quad <= n_quad;
        end
    end

    assign o_valid = r_v2;
    assign o_geom  = r_g2;
    assign o_quad  = r_quad;

endmodule

// ===== src/rsq_edge.sv =====
// One edge lane: parametric ray/segment test by cross-multiplied compares, five stages.
// Depends on rsq_pkg.
module rsq_edge #(
    parameter int FRAC_BITS = rsq_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rsq_pkg::t_geom   i_geom,
    input  rsq_pkg::t_corner i_x1,
    input  rsq_pkg::t_corner i_y1,
    input  rsq_pkg::t_corner i_x2,
    input  rsq_pkg::t_corner i_y2,
    output logic             o_valid,
    output logic             o_hit
);

    localparam int SW   = rsq_pkg::SW;
    localparam int DW   = rsq_pkg::DW;
    localparam int TW   = rsq_pkg::TW;
    localparam int CMPW = rsq_pkg::CMPW;
    localparam int DSPLIT = 26;
    localparam longint EPS = ((64'sd1 <<< FRAC_BITS) + 50) / 100;
    localparam longint PAR = ((64'sd1 <<< (14 + FRAC_BITS)) + 5000) / 10000;
    localparam logic signed [CMPW-1:0] EPS_W = CMPW'(EPS);
    localparam logic signed [CMPW-1:0] ONE_EPS_W = CMPW'((64'sd1 <<< FRAC_BITS) + EPS);
    localparam logic signed [DW:0] PAR_W = (DW+1)'(PAR);

    logic [4:0]             r_v;
    logic signed [15:0]     r_dx1, r_dy1;
    logic [30:0]            r_reach1, r_reach2, r_reach3;
    logic signed [SW-1:0]   r_sx, r_sy, r_rx, r_ry;
    logic signed [DW-2:0]   r_m1, r_m2, r_m5, r_m6;
    logic signed [TW-2:0]   r_m3, r_m4;
    logic signed [DW:0]     r_dn, r_un;
    logic signed [TW:0]     r_tn;
    logic                   r_par3, r_par4;
    logic signed [CMPW-1:0] r_ts, r_us, r_ed, r_od;
    logic [30+DSPLIT:0]     r_rd_lo;
    logic [30+DW-DSPLIT:0]  r_rd_hi;
    logic                   r_hit;
    logic signed [DW:0]     n_d, n_u, n_dabs;
    logic signed [TW:0]     n_t;
    logic signed [SW-1:0]   n_x1, n_y1;
    logic signed [CMPW-1:0] n_rd;

    always_comb begin
        n_d    = (DW+1)'(r_m1) - (DW+1)'(r_m2);
        n_t    = (TW+1)'(r_m3) - (TW+1)'(r_m4);
        n_u    = (DW+1)'(r_m5) - (DW+1)'(r_m6);
        n_dabs = n_d[DW] ? -n_d : n_d;
        n_x1   = SW'($signed(i_x1));
        n_y1   = SW'($signed(i_y1));
        // reach times |D|, rebuilt from the two partial products
        n_rd   = CMPW'({r_rd_hi, DSPLIT'(0)}) + CMPW'(r_rd_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edge vector and corner relative to the origin
            r_sx     <= SW'($signed(i_x2)) - n_x1;
            r_sy     <= SW'($signed(i_y2)) - n_y1;
            r_rx     <= n_x1 - SW'($signed(i_geom.ox));
            r_ry     <= n_y1 - SW'($signed(i_geom.oy));
            r_dx1    <= $signed(i_geom.dx);
            r_dy1    <= $signed(i_geom.dy);
            r_reach1 <= i_geom.reach;
            // cross products
            r_m1     <= r_dx1 * r_sy;
            r_m2     <= r_dy1 * r_sx;
            r_m3     <= r_rx * r_sy;
            r_m4     <= r_ry * r_sx;
            r_m5     <= r_rx * r_dy1;
            r_m6     <= r_ry * r_dx1;
            r_reach2 <= r_reach1;
            // make the denominator positive
            r_dn     <= n_dabs;
            r_tn     <= n_d[DW] ? -n_t : n_t;
            r_un     <= n_d[DW] ? -n_u : n_u;
            r_par3   <= n_dabs >= PAR_W;
            r_reach3 <= r_reach2;
            // scale both sides of each bound; split reach * |D| into two halves
            r_ts     <= CMPW'(r_tn) <<< 14;
            r_us     <= CMPW'(r_un) <<< FRAC_BITS;
            r_ed     <= EPS_W * CMPW'(r_dn);
            r_rd_lo  <= r_reach3 * r_dn[DSPLIT-1:0];
            r_rd_hi  <= r_reach3 * r_dn[DW-1:DSPLIT];
            r_od     <= ONE_EPS_W * CMPW'(r_dn);
            r_par4   <= r_par3;
            r_hit    <= r_par4 && (r_ts > r_ed) && (r_ts < n_rd) &&
                        (r_us >= -r_ed) && (r_us <= r_od);
        end
    end

    assign o_valid = r_v[4];
    assign o_hit   = r_hit;

endmodule

// ===== src/ray_square_occlusion_test.sv =====
// Ray versus rotated square occlusion test, fully pipelined.
// The CORDIC section takes one step per stage, with CORDIC_STEPS capped at 24.
// Throughput: one transaction per cycle; a stall at the output freezes the whole pipe.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
// Depends on rsq_pkg, rsq_front, rsq_cordic, rsq_corner, rsq_edge.
module ray_square_occlusion_test #(
    parameter int FRAC_BITS    = rsq_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = rsq_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [30:0] i_reach,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [30:0] i_side,
    input  logic [15:0] i_heading,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_blocked,
    output logic [1:0]  o_outcome
);

    localparam int EDGE_LAT = 5;

    logic               w_adv;
    rsq_pkg::t_geom     w_in_geom;
    logic               w_front_v, w_cordic_v, w_corner_v;
    rsq_pkg::t_geom     w_front_g, w_cordic_g, w_corner_g;
    logic signed [33:0] w_cos, w_sin;
    rsq_pkg::t_quad     w_quad;
    logic [3:0]         w_lane_v;
    logic [3:0]         w_hit;
    logic [1:0]         r_oc [0:EDGE_LAT-1];
    logic               r_out_valid;
    logic               r_blocked;
    logic [1:0]         r_outcome;
    logic [1:0]         n_outcome;

    // Advance everything whenever the output slot is empty or being drained
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Pack the transaction; keep only the floor of half the side
    always_comb begin
        w_in_geom.ox      = i_origin_x;
        w_in_geom.oy      = i_origin_y;
        w_in_geom.dx      = i_dir_x;
        w_in_geom.dy      = i_dir_y;
        w_in_geom.reach   = i_reach;
        w_in_geom.cx      = i_center_x;
        w_in_geom.cy      = i_center_y;
        w_in_geom.h       = i_side[30:1];
        w_in_geom.heading = i_heading;
        w_in_geom.outcome = rsq_pkg::OUT_MISS;
    end

    // Behind-origin and beyond-reach screening
    rsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in_valid),
        .i_geom  (w_in_geom),
        .o_valid (w_front_v),
        .o_geom  (w_front_g)
    );

    // Sine and cosine of the heading; always run, the screening result rides along
    rsq_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_front_v),
        .i_geom  (w_front_g),
        .o_valid (w_cordic_v),
        .o_geom  (w_cordic_g),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // Rotated corners
    rsq_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_cordic_v),
        .i_geom  (w_cordic_g),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_valid (w_corner_v),
        .o_geom  (w_corner_g),
        .o_quad  (w_quad)
    );

    // Edge lanes in parallel, one per side: TL-TR, TR-BR, BR-BL, BL-TL
    for (genvar e = 0; e < 4; e++) begin : g_edge
        rsq_edge #(
            .FRAC_BITS (FRAC_BITS)
        ) u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_corner_v),
            .i_geom  (w_corner_g),
            .i_x1    (w_quad.x[e]),
            .i_y1    (w_quad.y[e]),
            .i_x2    (w_quad.x[(e + 1) % 4]),
            .i_y2    (w_quad.y[(e + 1) % 4]),
            .o_valid (w_lane_v[e]),
            .o_hit   (w_hit[e])
        );
    end

    // Carry the screening outcome alongside the edge lanes
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oc[0] <= w_corner_g.outcome;
            for (int k = 1; k < EDGE_LAT; k++) begin
                r_oc[k] <= r_oc[k-1];
            end
        end
    end

    // A screened-out obstacle keeps its code; otherwise any lane hit wins
    always_comb begin
        if (r_oc[EDGE_LAT-1] == rsq_pkg::OUT_MISS && (|w_hit)) begin
            n_outcome = rsq_pkg::OUT_HIT;
        end else begin
            n_outcome = r_oc[EDGE_LAT-1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_lane_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_outcome <= n_outcome;
            r_blocked <= (n_outcome == rsq_pkg::OUT_HIT);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_blocked   = r_blocked;
    assign o_outcome   = r_outcome;

endmodule

// ===== verif/ray_square_occlusion_test_tb.sv =====
// Self-checking testbench for ray_square_occlusion_test: random and directed ray/square pairs.
// Depends on rsq_pkg (outcome codes) and the ray_square_occlusion_test RTL.
`timescale 1ns / 100ps

module ray_square_occlusion_test_tb;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [30:0] reach;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] side;
        logic [15:0] heading;
    } t_ray_pair;

    typedef struct {
        logic       blocked;
        logic [1:0] outcome;
    } t_verdict;

    localparam longint ONE       = 64'sd65536;
    localparam longint EPS_Q     = (ONE + 50) / 100;
    localparam longint PAR_MIN   = ((64'sd1 << 30) + 5000) / 10000;
    localparam int     N_STEPS   = 16;
    localparam int     N_RANDOM  = 1700;
    localparam int     IDLE_LIMIT = 5000;

    // CORDIC angle table, 2^32 per turn
    localparam longint ATAN_TBL [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_origin_x = '0;
    logic [31:0] i_origin_y = '0;
    logic [15:0] i_dir_x = '0;
    logic [15:0] i_dir_y = '0;
    logic [30:0] i_reach = '0;
    logic [31:0] i_center_x = '0;
    logic [31:0] i_center_y = '0;
    logic [30:0] i_side = '0;
    logic [15:0] i_heading = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_blocked;
    logic [1:0]  o_outcome;

    ray_square_occlusion_test uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_reach(i_reach),
        .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_side(i_side), .i_heading(i_heading),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_blocked(o_blocked), .o_outcome(o_outcome)
    );

    always #6 i_clk = ~i_clk;

    t_ray_pair pending_pairs[$];
    t_verdict  expected_verdicts[$];
    int        errors = 0;
    int        pairs_sent = 0;
    int        idle_cycles = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Exact parametric ray/segment test, divisions turned into
    // cross-multiplied compares after normalizing the sign of D.
    function automatic bit edge_blocks(longint ox, longint oy, longint dx, longint dy,
                                       longint x1, longint y1, longint x2, longint y2,
                                       longint rch);
        longint sx, sy, rx, ry, d, u;
        t_wide  t, wu, ts, us, wd;
        sx = x2 - x1;
        sy = y2 - y1;
        rx = x1 - ox;
        ry = y1 - oy;
        d  = dx * sy - dy * sx;
        if ((d < 0 ? -d : d) < PAR_MIN)
            return 1'b0;
        t  = t_wide'(rx) * t_wide'(sy) - t_wide'(ry) * t_wide'(sx);
        u  = rx * dy - ry * dx;
        wu = t_wide'(u);
        if (d < 0) begin
            d  = -d;
            t  = -t;
            wu = -wu;
        end
        wd = t_wide'(d);
        ts = t <<< 14;
        us = wu <<< 16;
        if (ts <= t_wide'(EPS_Q) * wd)
            return 1'b0;
        if (ts >= t_wide'(rch) * wd)
            return 1'b0;
        if (us < -(t_wide'(EPS_Q) * wd))
            return 1'b0;
        if (us > t_wide'(ONE + EPS_Q) * wd)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_verdict occlusion_verdict(t_ray_pair p);
        longint   ox, oy, dx, dy, rch, cx, cy, h, tx, ty;
        longint   a, b, ps, qs, x, y, xs, ys, zs, cs, sn;
        longint   kx[4], ky[4];
        logic [31:0] z;
        bit       flip;
        t_verdict v;
        ox  = longint'($signed(p.ox));
        oy  = longint'($signed(p.oy));
        dx  = longint'($signed(p.dx));
        dy  = longint'($signed(p.dy));
        rch = longint'(p.reach);
        cx  = longint'($signed(p.cx));
        cy  = longint'($signed(p.cy));
        h   = longint'(p.side >> 1);
        tx  = cx - ox;
        ty  = cy - oy;
        v.outcome = rsq_pkg::OUT_MISS;
        if (tx * dx + ty * dy < 0) begin
            v.outcome = rsq_pkg::OUT_BEHIND;
        end else if (t_wide'(tx) * t_wide'(tx) + t_wide'(ty) * t_wide'(ty)
                     > t_wide'(rch) * t_wide'(rch)) begin
            v.outcome = rsq_pkg::OUT_BEYOND;
        end else begin
            if (p.heading == 16'd0) begin
                a = h;
                b = 0;
            end else begin
                // fold the left half-plane onto the right, then rotate
                z    = {p.heading, 16'h0000};
                flip = (z >= 32'h4000_0000) && (z < 32'hC000_0000);
                if (flip)
                    z = z ^ 32'h8000_0000;
                zs = longint'($signed(z));
                x  = 652032874;
                y  = 0;
                for (int i = 0; i < N_STEPS && i < 24; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (zs >= 0) begin
                        x  = x - ys;
                        y  = y + xs;
                        zs = zs - ATAN_TBL[i];
                    end else begin
                        x  = x + ys;
                        y  = y - xs;
                        zs = zs + ATAN_TBL[i];
                    end
                end
                cs = flip ? -x : x;
                sn = flip ? -y : y;
                a  = (h * cs + (64'sd1 <<< 29)) >>> 30;
                b  = (h * sn + (64'sd1 <<< 29)) >>> 30;
            end
            ps = a + b;
            qs = a - b;
            kx[0] = cx - ps; ky[0] = cy + qs;
            kx[1] = cx + qs; ky[1] = cy + ps;
            kx[2] = cx + ps; ky[2] = cy - qs;
            kx[3] = cx - qs; ky[3] = cy - ps;
            for (int i = 0; i < 4; i++) begin
                if (v.outcome == rsq_pkg::OUT_MISS &&
                    edge_blocks(ox, oy, dx, dy, kx[i], ky[i],
                                kx[(i + 1) % 4], ky[(i + 1) % 4], rch))
                    v.outcome = rsq_pkg::OUT_HIT;
            end
        end
        v.blocked = (v.outcome == rsq_pkg::OUT_HIT);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Build a pair whose square sits near the ray: along the ray by
    // along_len, off across it, all lengths in Q16.16.
    function automatic t_ray_pair aimed_pair(longint along_len, longint off, longint side_len,
                                             logic [15:0] hd, longint rch);
        t_ray_pair p;
        real       th;
        longint    ox, oy, dx, dy;
        th = $urandom_range(0, 62831) / 10000.0;
        dx = $rtoi(16384.0 * $cos(th));
        dy = $rtoi(16384.0 * $sin(th));
        ox = longint'($urandom_range(0, 33554432)) - 16777216;
        oy = longint'($urandom_range(0, 33554432)) - 16777216;
        p.ox      = 32'(ox);
        p.oy      = 32'(oy);
        p.dx      = 16'(dx);
        p.dy      = 16'(dy);
        p.cx      = 32'(ox + ((dx * along_len - dy * off) >>> 14));
        p.cy      = 32'(oy + ((dy * along_len + dx * off) >>> 14));
        p.side    = 31'(side_len);
        p.heading = hd;
        p.reach   = 31'(rch);
        return p;
    endfunction

    function automatic t_ray_pair noise_pair();
        t_ray_pair p;
        p.ox      = $urandom;
        p.oy      = $urandom;
        p.dx      = 16'($urandom);
        p.dy      = 16'($urandom);
        p.reach   = 31'($urandom);
        p.cx      = $urandom;
        p.cy      = $urandom;
        p.side    = 31'($urandom);
        p.heading = 16'($urandom);
        return p;
    endfunction

    task automatic queue_pair(t_ray_pair p);
        pending_pairs = {pending_pairs, p};
    endtask

    task automatic note_expected(t_ray_pair p);
        expected_verdicts = {expected_verdicts, occlusion_verdict(p)};
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Driver: one transaction per pending pair, random gap after each
    // ---------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            // the previous transaction (if any) was taken at this edge
            if (i_in_valid) begin
                note_expected('{
                    i_origin_x, i_origin_y, i_dir_x, i_dir_y, i_reach,
                    i_center_x, i_center_y, i_side, i_heading});
                pairs_sent++;
            end
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if ((pairs_sent == 20 || pairs_sent == 900) &&
                         (expected_verdicts.size() != 0 || i_in_valid)) begin
                // drain the pipe completely before going on
                i_in_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                t_ray_pair p;
                p = pending_pairs.pop_front();
                i_origin_x <= p.ox;
                i_origin_y <= p.oy;
                i_dir_x    <= p.dx;
                i_dir_y    <= p.dy;
                i_reach    <= p.reach;
                i_center_x <= p.cx;
                i_center_y <= p.cy;
                i_side     <= p.side;
                i_heading  <= p.heading;
                i_in_valid <= 1'b1;
                // every fourth block of 64 pairs runs back to back
                gap_left   <= (pairs_sent[7:6] == 2'b11) ? 0 : $urandom_range(0, 17);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random output stalls, compare against oldest expectation
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            int s;
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result, outcome", o_outcome, -1);
            end else begin
                t_verdict e;
                e = expected_verdicts.pop_front();
                if (o_blocked !== e.blocked)
                    report_mismatch("blocked", o_blocked, e.blocked);
                if (o_outcome !== e.outcome)
                    report_mismatch("outcome", o_outcome, e.outcome);
            end
            s = (pairs_sent[7:6] == 2'b01) ? 0 : $urandom_range(0, 17);
            stall_left  <= s;
            i_out_ready <= (s == 0);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        t_ray_pair p;
        int        kind;
        longint    along_len, off, sd, rch;

        // extremes of every field
        p = '{32'h0, 32'h0, 16'h0, 16'h0, 31'h0, 32'h0, 32'h0, 31'h0, 16'h0};
        queue_pair(p);
        p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF};
        queue_pair(p);
        p = '{32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 31'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 16'h8000};
        queue_pair(p);
        p = '{32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h4000};
        queue_pair(p);
        // axis aligned hit, square straight ahead on +x
        p = '{32'h0, 32'h0, 16'd16384, 16'h0, 31'(20 * ONE),
              32'(10 * ONE), 32'h0, 31'(2 * ONE), 16'h0};
        queue_pair(p);
        // same square rotated by quarter turns and odd angles
        p.heading = 16'h4000; queue_pair(p);
        p.heading = 16'h8000; queue_pair(p);
        p.heading = 16'hC000; queue_pair(p);
        p.heading = 16'h2000; queue_pair(p);
        p.heading = 16'hFFFF; queue_pair(p);
        // behind the origin
        p.heading = 16'h0; p.cx = 32'(-10 * ONE); queue_pair(p);
        // beyond reach
        p.cx = 32'(10 * ONE); p.reach = 31'(5 * ONE); queue_pair(p);
        // ray along an edge line, that edge parallel, touches the square at its corners
        p.reach = 31'(20 * ONE); p.cy = 32'(ONE); queue_pair(p);
        // grazing the corner line just outside
        p.cy = 32'(ONE + 700); queue_pair(p);
        // zero side, zero reach, zero direction
        p.cy = 32'h0; p.side = 31'h0; queue_pair(p);
        p.side = 31'(2 * ONE); p.reach = 31'h0; p.cx = 32'h0; queue_pair(p);
        p.reach = 31'(20 * ONE); p.dx = 16'h0; queue_pair(p);
        // non-unit direction, origin inside the square
        p.dx = 16'h7FFF; p.dy = 16'h1234; p.cx = 32'(ONE / 4); queue_pair(p);
        // hit near the reach limit
        queue_pair(aimed_pair(10 * ONE, 0, 2 * ONE, 16'h0, 9 * ONE + 100));
        queue_pair(aimed_pair(10 * ONE, 0, 2 * ONE, 16'h1555, 9 * ONE));

        // random part, mostly pairs aimed near the square
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                queue_pair(noise_pair());
            end else begin
                along_len = longint'($urandom_range(0, 100 * 65536));
                if (kind < 25)
                    along_len = -along_len;
                sd  = ($urandom_range(0, 19) == 0) ? longint'($urandom)
                                                   : longint'($urandom_range(0, 40 * 65536));
                off = longint'($urandom_range(0, 2 * 65536 + 60 * 65536)) - 31 * 65536;
                off = off / longint'($urandom_range(1, 4));
                rch = ($urandom_range(0, 4) == 0) ? longint'($urandom_range(0, 120 * 65536))
                                                  : along_len +
                                                    longint'($urandom_range(0, 50 * 65536));
                if (rch < 0)
                    rch = -rch;
                queue_pair(aimed_pair(along_len, off, sd,
                    ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom), rch));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
